// ----- src/its_pkg.sv -----
// Shared types and constants of the indent token scanner.
package its_pkg;

   // Depth of the indent level stack, base entry included.
   localparam int STACK_DEPTH = 64;
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int LEVEL_WIDTH = 16;
   localparam int TAB_WIDTH_BITS = 5;
   localparam logic [TAB_WIDTH_BITS-1:0] TAB_WIDTH_RESET = 5'd4;

   // Character codes that the scanner looks at.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef logic [LEVEL_WIDTH-1:0] level_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      TOKEN_INDENT  = 2'd0,
      TOKEN_DEDENT  = 2'd1,
      TOKEN_NEWLINE = 2'd2,
      TOKEN_NONE    = 2'd3
   } token_kind_type;

   // Command from the scanner to the level stack.
   typedef struct packed {
      logic      push;
      logic      pop;
      level_type push_level;
   } stack_cmd_type;

   // Status from the level stack to the scanner.
   typedef struct packed {
      level_type top_level;
      logic      full;
      logic      above_base;
   } stack_status_type;

endpackage

// ----- src/its_if.sv -----
// Channel interfaces of the indent token scanner.
interface its_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;
   logic       call_start;
   logic       indent_allowed;
   logic       dedent_allowed;
   logic       newline_allowed;

   modport source (output valid, char_code, end_of_input, call_start,
                   indent_allowed, dedent_allowed, newline_allowed,
                   input ready);
   modport sink (input valid, char_code, end_of_input, call_start,
                 indent_allowed, dedent_allowed, newline_allowed,
                 output ready);
endinterface

interface its_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_kind;
   logic       stack_overflow;

   modport source (output valid, token_kind, stack_overflow, input ready);
   modport sink (input valid, token_kind, stack_overflow, output ready);
endinterface

interface its_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] tab_width;

   modport source (output valid, tab_width, input ready);
   modport sink (input valid, tab_width, output ready);
endinterface

// ----- src/its_stack_cell.sv -----
// One cell of the indent level stack: holds a level and shifts with its neighbors.
module its_stack_cell (
   input  logic              clock,
   input  logic              shift_down,
   input  logic              shift_up,
   input  its_pkg::level_type from_above,
   input  its_pkg::level_type from_below,
   output its_pkg::level_type level
);
   import its_pkg::*;

   level_type level_ff;
   level_type level_in;

   // A push moves every level one cell deeper, a pop one cell shallower.
   always_comb begin
      level_in = level_ff;
      if (shift_down) begin
         level_in = from_above;
      end else if (shift_up) begin
         level_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

// ----- src/its_level_stack.sv -----
// Indent level stack: a registered top and a row of shifting cells below it.
module its_level_stack (
   input  logic                     clock,
   input  logic                     reset,
   input  its_pkg::stack_cmd_type    cmd,
   output its_pkg::stack_status_type status
);
   import its_pkg::*;

   localparam int NUM_CELLS = STACK_DEPTH - 1;

   level_type top_ff;
   level_type top_in;
   count_type count_ff;
   count_type count_in;
   level_type cell_level [NUM_CELLS];

   // The top of the stack; the base level is zero after reset.
   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.push) begin
         top_in   = cmd.push_level;
         count_in = count_ff + count_type'(1);
      end else if (cmd.pop) begin
         top_in   = cell_level[0];
         count_in = count_ff - count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         count_ff <= count_type'(1);
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   // The row of cells; cell 0 sits just under the top.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      level_type above;
      level_type below;

      if (i == 0) begin : g_first
         assign above = top_ff;
      end else begin : g_inner
         assign above = cell_level[i-1];
      end

      if (i == NUM_CELLS - 1) begin : g_last
         assign below = '0;
      end else begin : g_next
         assign below = cell_level[i+1];
      end

      its_stack_cell u_cell (
         .clock      (clock),
         .shift_down (cmd.push),
         .shift_up   (cmd.pop),
         .from_above (above),
         .from_below (below),
         .level      (cell_level[i])
      );
   end

   assign status.top_level  = top_ff;
   assign status.full       = (count_ff == count_type'(STACK_DEPTH));
   assign status.above_base = (count_ff > count_type'(1));

   // The count always covers the base entry and never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff >= count_type'(1)) && (count_ff <= count_type'(STACK_DEPTH)))
      else $error("level stack count out of range");

   // A push and a pop never come together.
   assert property (@(posedge clock) disable iff (reset) !(cmd.push && cmd.pop))
      else $error("level stack push and pop in one cycle");

   // A pushed level becomes the new top.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (top_ff == $past(cmd.push_level)))
      else $error("pushed level is not the top");

   // A push never lands on a full stack, and a pop never removes the base.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && status.full) && !(cmd.pop && !status.above_base))
      else $error("level stack overrun");

endmodule

// ----- src/indent_token_scanner.sv -----
// Top level of the indent token scanner: character scan, token decision and result buffer.
//
// Usage: each beat on req carries one lookahead character of a scan call; the first
// beat of a call has call_start set and carries the three permission bits. Spaces and
// tabs grow the indent count, CR, LF and end of input mark a line end. Any other
// character, or end of input, ends the call and yields one beat on rsp with the token
// kind and a stack overflow flag. Beats between the end of a call and the next start
// are consumed and ignored.
// Throughput: one req beat per cycle. The indent compare and the stack update for a
// call end happen in the cycle its last character is accepted, so the next character
// sees the new stack top at once. The rsp beat comes from an output register backed
// by one skid register. When rsp stalls, a second result goes to the skid register;
// only while that is full does req_chan.ready drop. The csr channel is always ready;
// tab_width takes effect on the next character. Reset (synchronous) empties the
// stack to its base level of zero, sets tab_width to 4, drops both result registers
// and leaves the scanner waiting for a call start. There is no clearing pass.
module indent_token_scanner (
   input  logic clock,
   input  logic reset,
   its_req_if.sink   req_chan,
   its_rsp_if.source rsp_chan,
   its_csr_if.sink   csr_chan
);
   import its_pkg::*;

   // Configuration register.
   logic [TAB_WIDTH_BITS-1:0] tab_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_WIDTH_RESET;
      end else if (csr_chan.valid) begin
         tab_width_ff <= csr_chan.tab_width;
      end
   end

   assign csr_chan.ready = 1'b1;

   // Scan state.
   level_type  indent_count_ff;
   level_type  indent_count_in;
   logic       line_end_ff;
   logic       line_end_in;
   logic       finished_ff;
   logic       finished_in;
   logic [2:0] perm_ff;
   logic [2:0] perm_in;

   logic             req_fire;
   logic             active;
   logic             ends_call;
   logic             is_space;
   logic             is_tab;
   logic             is_line_break;
   level_type        base_count;
   logic             base_line_end;
   logic [2:0]       perm_now;
   level_type        final_count;
   logic             final_line_end;
   token_kind_type   kind;
   logic             overflow;
   stack_cmd_type    stack_cmd;
   stack_status_type stack_status;
   logic             produce;

   its_level_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stack_cmd),
      .status (stack_status)
   );

   // Classify the character and pick up the state of the open or new call.
   always_comb begin
      req_fire       = req_chan.valid && req_chan.ready;
      active         = req_chan.call_start || !finished_ff;
      is_space       = (req_chan.char_code == CHAR_SPACE);
      is_tab         = (req_chan.char_code == CHAR_TAB);
      is_line_break  = (req_chan.char_code == CHAR_CR) || (req_chan.char_code == CHAR_LF);
      ends_call      = req_chan.end_of_input || !(is_space || is_tab || is_line_break);
      base_count     = req_chan.call_start ? '0 : indent_count_ff;
      base_line_end  = req_chan.call_start ? 1'b0 : line_end_ff;
      perm_now       = req_chan.call_start ?
                       {req_chan.newline_allowed, req_chan.dedent_allowed,
                        req_chan.indent_allowed} : perm_ff;
      final_count    = req_chan.end_of_input ? '0 : base_count;
      final_line_end = req_chan.end_of_input || base_line_end;
   end

   // Token decision at the end of a call.
   always_comb begin
      kind      = TOKEN_NONE;
      overflow  = 1'b0;
      stack_cmd = '{push: 1'b0, pop: 1'b0, push_level: final_count};
      if (final_line_end) begin
         if (perm_now[0] && (final_count > stack_status.top_level)) begin
            kind           = TOKEN_INDENT;
            overflow       = stack_status.full;
            stack_cmd.push = req_fire && active && ends_call && !stack_status.full;
         end else if (perm_now[1] && (final_count < stack_status.top_level)) begin
            kind          = TOKEN_DEDENT;
            stack_cmd.pop = req_fire && active && ends_call && stack_status.above_base;
         end else if (perm_now[2]) begin
            kind = TOKEN_NEWLINE;
         end
      end
      produce = req_fire && active && ends_call;
   end

   // Next scan state: counting while the call stays open.
   always_comb begin
      indent_count_in = indent_count_ff;
      line_end_in     = line_end_ff;
      finished_in     = finished_ff;
      perm_in         = perm_ff;
      if (req_fire && active) begin
         perm_in         = perm_now;
         line_end_in     = final_line_end;
         indent_count_in = final_count;
         finished_in     = ends_call;
         if (!ends_call) begin
            if (is_space) begin
               indent_count_in = base_count + level_type'(1);
            end else if (is_tab) begin
               indent_count_in = base_count + level_type'(tab_width_ff);
            end else begin
               indent_count_in = '0;
               line_end_in     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         indent_count_ff <= '0;
         line_end_ff     <= 1'b0;
         finished_ff     <= 1'b1;
         perm_ff         <= '0;
      end else begin
         indent_count_ff <= indent_count_in;
         line_end_ff     <= line_end_in;
         finished_ff     <= finished_in;
         perm_ff         <= perm_in;
      end
   end

   // Result buffer: output register plus one skid register.
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   token_kind_type out_kind_ff;
   token_kind_type out_kind_in;
   logic           out_ovf_ff;
   logic           out_ovf_in;
   token_kind_type skid_kind_ff;
   token_kind_type skid_kind_in;
   logic           skid_ovf_ff;
   logic           skid_ovf_in;
   logic           rsp_fire;

   always_comb begin
      rsp_fire      = out_valid_ff && rsp_chan.ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_kind_in   = out_kind_ff;
      out_ovf_in    = out_ovf_ff;
      skid_kind_in  = skid_kind_ff;
      skid_ovf_in   = skid_ovf_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_kind_in   = skid_kind_ff;
            out_ovf_in    = skid_ovf_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || rsp_fire) begin
            out_kind_in  = kind;
            out_ovf_in   = overflow;
            out_valid_in = 1'b1;
         end else begin
            skid_kind_in  = kind;
            skid_ovf_in   = overflow;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_ovf_ff   <= out_ovf_in;
      skid_kind_ff <= skid_kind_in;
      skid_ovf_ff  <= skid_ovf_in;
   end

   assign req_chan.ready          = !skid_valid_ff;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.token_kind     = out_kind_ff;
   assign rsp_chan.stack_overflow = out_ovf_ff;

   // The skid register only fills behind a waiting output register.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // An overflow flag only comes with an INDENT token.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovf_ff) |-> (out_kind_ff == TOKEN_INDENT))
      else $error("overflow flagged on a token other than INDENT");

   // A call end always leaves the scanner waiting for the next start.
   assert property (@(posedge clock) disable iff (reset) produce |=> finished_ff)
      else $error("call end did not close the call");

endmodule

// ----- bench/indent_token_scanner_tb.sv -----
// Self-checking testbench of the indent token scanner: random and directed character streams.
module indent_token_scanner_tb;
   import its_pkg::*;

   // Permission bits as they travel on a call start beat.
   localparam logic [2:0] PERM_INDENT  = 3'b001;
   localparam logic [2:0] PERM_DEDENT  = 3'b010;
   localparam logic [2:0] PERM_NEWLINE = 3'b100;
   localparam logic [2:0] PERM_ALL     = 3'b111;
   localparam logic [2:0] PERM_NONE    = 3'b000;
   localparam int MAX_WAIT    = 12;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      logic       start;
      logic [2:0] perm;
   } char_beat_type;

   typedef struct {
      token_kind_type kind;
      logic           ovf;
   } token_result_type;

   logic clock;
   logic reset;

   its_req_if req_bus ();
   its_rsp_if rsp_bus ();
   its_csr_if csr_bus ();

   indent_token_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Characters waiting to be sent and tokens waiting to come back.
   char_beat_type    char_backlog[$];
   token_result_type expected_tokens[$];

   // Scanner state as the bench tracks it.
   level_type                 level_stack[STACK_DEPTH];
   int                        stack_depth;
   level_type                 col_count;
   bit                        line_end_seen;
   bit                        scan_idle;
   logic [2:0]                call_perms;
   logic [TAB_WIDTH_BITS-1:0] tab_cols;

   bit paced;
   int send_gap;
   int rsp_hold;
   int idle_cycles;
   int failures;
   int beats_in;
   int tokens_seen;
   int indents_seen;
   int drops_seen;
   int dedents_seen;
   int newlines_seen;

   // Advances the tracked scanner by one accepted beat; returns 1 when a token is due.
   function automatic bit scan_char(input char_beat_type b, output token_result_type res);
      bit        ends;
      level_type top;
      res.kind = TOKEN_NONE;
      res.ovf  = 1'b0;
      ends     = 1'b0;
      if (b.start) begin
         scan_idle     = 1'b0;
         col_count     = '0;
         line_end_seen = 1'b0;
         call_perms    = b.perm;
      end else if (scan_idle) begin
         return 1'b0;
      end
      if (b.eoi) begin
         col_count     = '0;
         line_end_seen = 1'b1;
         ends          = 1'b1;
      end else begin
         case (b.ch)
            CHAR_SPACE: col_count = col_count + level_type'(1);
            CHAR_TAB:   col_count = col_count + level_type'(tab_cols);
            CHAR_CR, CHAR_LF: begin
               line_end_seen = 1'b1;
               col_count     = '0;
            end
            default:    ends = 1'b1;
         endcase
      end
      if (!ends) return 1'b0;
      // The call is over: compare against the innermost level.
      scan_idle = 1'b1;
      if (line_end_seen) begin
         top = level_stack[stack_depth-1];
         if ((call_perms & PERM_INDENT) != 0 && col_count > top) begin
            if (stack_depth < STACK_DEPTH) begin
               level_stack[stack_depth] = col_count;
               stack_depth = stack_depth + 1;
            end else begin
               res.ovf = 1'b1;
            end
            res.kind = TOKEN_INDENT;
         end else if ((call_perms & PERM_DEDENT) != 0 && col_count < top) begin
            if (stack_depth > 1) stack_depth = stack_depth - 1;
            res.kind = TOKEN_DEDENT;
         end else if ((call_perms & PERM_NEWLINE) != 0) begin
            res.kind = TOKEN_NEWLINE;
         end
      end
      return 1'b1;
   endfunction

   function automatic int draw_wait();
      return paced ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   // Any byte that ends a call.
   function automatic logic [7:0] pick_glyph();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   // Whitespace or a line end, weighted toward indentation.
   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 5))
         0, 1:    return CHAR_SPACE;
         2, 3:    return CHAR_TAB;
         4:       return CHAR_LF;
         default: return CHAR_CR;
      endcase
   endfunction

   task automatic add_beat(input logic [7:0] ch, input logic eoi, input logic start,
                           input logic [2:0] perm);
      char_beat_type b;
      b.ch    = ch;
      b.eoi   = eoi;
      b.start = start;
      b.perm  = perm;
      char_backlog.push_back(b);
   endtask

   function automatic logic [2:0] any_perm();
      return 3'($urandom_range(0, 7));
   endfunction

   // One scan call with random content; some are cut short by the next start.
   task automatic add_call();
      logic [2:0] perm;
      int         shape;
      perm  = any_perm();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         if ($urandom_range(0, 1) == 1) add_beat(pick_glyph(), 1'b0, 1'b1, perm);
         else add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, perm);
      end else begin
         add_beat(($urandom_range(0, 1) == 1) ? CHAR_LF : pick_blank(), 1'b0, 1'b1, perm);
         repeat ($urandom_range(0, 6)) add_beat(pick_blank(), 1'b0, 1'b0, any_perm());
         if (shape != 1) begin
            if ($urandom_range(0, 3) == 0)
               add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, any_perm());
            else
               add_beat(pick_glyph(), 1'b0, 1'b0, any_perm());
         end
      end
      // Stray beats between calls.
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2))
            add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                     any_perm());
      end
   endtask

   // Wait until every beat is sent and every token is back, then let the block settle.
   task automatic drain();
      do @(negedge clock);
      while (char_backlog.size() != 0 || req_bus.valid || expected_tokens.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_tab(input logic [TAB_WIDTH_BITS-1:0] w);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.tab_width <= w;
      do @(posedge clock);
      while (!csr_bus.ready);
      tab_cols = w;
      csr_bus.valid <= 1'b0;
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Character driver: one beat at a time from the backlog, with random gaps.
   always @(posedge clock) begin : char_driver
      char_beat_type    b;
      token_result_type r;
      char_beat_type    nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            b.ch     = req_bus.char_code;
            b.eoi    = req_bus.end_of_input;
            b.start  = req_bus.call_start;
            b.perm   = {req_bus.newline_allowed, req_bus.dedent_allowed,
                        req_bus.indent_allowed};
            beats_in = beats_in + 1;
            if (scan_char(b, r)) expected_tokens.push_back(r);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (char_backlog.size() != 0) begin
               nxt = char_backlog.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.char_code       <= nxt.ch;
               req_bus.end_of_input    <= nxt.eoi;
               req_bus.call_start      <= nxt.start;
               req_bus.indent_allowed  <= nxt.perm[0];
               req_bus.dedent_allowed  <= nxt.perm[1];
               req_bus.newline_allowed <= nxt.perm[2];
               send_gap                <= draw_wait();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Token monitor: compares each beat with the oldest expected token, stalls at random.
   always @(posedge clock) begin : token_monitor
      token_result_type want;
      int               hold;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            tokens_seen = tokens_seen + 1;
            if (expected_tokens.size() == 0) begin
               $display("%0t: token with none expected: kind %0d overflow %0d", $time,
                        rsp_bus.token_kind, rsp_bus.stack_overflow);
               failures = failures + 1;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_bus.token_kind !== want.kind) begin
                  $display("%0t: token kind: expected %0d, actual %0d", $time,
                           want.kind, rsp_bus.token_kind);
                  failures = failures + 1;
               end
               if (rsp_bus.stack_overflow !== want.ovf) begin
                  $display("%0t: stack overflow flag: expected %0d, actual %0d", $time,
                           want.ovf, rsp_bus.stack_overflow);
                  failures = failures + 1;
               end
               case (want.kind)
                  TOKEN_INDENT: begin
                     indents_seen = indents_seen + 1;
                     if (want.ovf) drops_seen = drops_seen + 1;
                  end
                  TOKEN_DEDENT:  dedents_seen = dedents_seen + 1;
                  TOKEN_NEWLINE: newlines_seen = newlines_seen + 1;
                  default: ;
               endcase
            end
            hold = draw_wait();
            if (hold == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               rsp_hold      <= hold - 1;
            end
         end else if (rsp_hold > 0) begin
            rsp_hold      <= rsp_hold - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d tokens outstanding", $time,
                     idle_cycles, expected_tokens.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Stimulus: directed calls, a full-stack ladder, then random phases per tab width.
   initial begin : stimulus
      logic [TAB_WIDTH_BITS-1:0] widths[6];
      int                        goal;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.char_code       = '0;
      req_bus.end_of_input    = 1'b0;
      req_bus.call_start      = 1'b0;
      req_bus.indent_allowed  = 1'b0;
      req_bus.dedent_allowed  = 1'b0;
      req_bus.newline_allowed = 1'b0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.tab_width       = '0;
      level_stack[0] = '0;
      stack_depth    = 1;
      col_count      = '0;
      line_end_seen  = 1'b0;
      scan_idle      = 1'b1;
      call_perms     = '0;
      tab_cols       = TAB_WIDTH_RESET;
      paced          = 1'b1;
      failures       = 0;
      beats_in       = 0;
      tokens_seen    = 0;
      indents_seen   = 0;
      drops_seen     = 0;
      dedents_seen   = 0;
      newlines_seen  = 0;

      // Directed calls at the reset tab width.
      add_beat("a", 1'b0, 1'b0, PERM_ALL);               // no call open yet: ignored
      add_beat(CHAR_SPACE, 1'b0, 1'b1, PERM_ALL);        // call with no line end
      add_beat("a", 1'b0, 1'b0, PERM_NONE);
      add_beat(CHAR_LF, 1'b0, 1'b1, PERM_INDENT);        // two spaces and a tab: indent
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_NONE);
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_NONE);
      add_beat(CHAR_TAB, 1'b0, 1'b0, PERM_NONE);
      add_beat("x", 1'b0, 1'b0, PERM_NONE);
      add_beat("y", 1'b0, 1'b0, PERM_ALL);               // after the call end: ignored
      add_beat(CHAR_CR, 1'b0, 1'b1, PERM_DEDENT);        // shallower line: dedent
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_NONE);
      add_beat(8'hFF, 1'b0, 1'b0, PERM_ALL);
      add_beat(CHAR_LF, 1'b0, 1'b1, PERM_NEWLINE);       // same level: newline
      add_beat(8'h00, 1'b0, 1'b0, PERM_NONE);
      add_beat(CHAR_LF, 1'b0, 1'b1, PERM_INDENT | PERM_DEDENT);
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_NONE);
      add_beat("z", 1'b0, 1'b1, PERM_ALL);               // restart abandons the open call
      add_beat(8'hFF, 1'b1, 1'b1, PERM_NEWLINE);         // end of input on the first beat
      add_beat(CHAR_SPACE, 1'b0, 1'b1, PERM_INDENT);     // end of input clears the count
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_NONE);
      add_beat(8'h00, 1'b1, 1'b0, PERM_ALL);
      add_beat(CHAR_LF, 1'b0, 1'b1, PERM_NONE);          // deeper line, nothing allowed
      add_beat(CHAR_SPACE, 1'b0, 1'b0, PERM_ALL);
      add_beat("q", 1'b0, 1'b0, PERM_ALL);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      drain();

      // Ladder of ever deeper lines: the tab width and a few tabs set each depth, so
      // the stack fills with short calls and then overflows; a few dedents follow.
      for (int tabs = 1; tabs <= 4; tabs++) begin
         for (int w = 1; w <= 31; w++) begin
            if (level_type'(tabs * w) > level_stack[stack_depth-1]) begin
               write_tab(5'(w));
               add_beat(CHAR_LF, 1'b0, 1'b1, PERM_INDENT | any_perm());
               repeat (tabs) add_beat(CHAR_TAB, 1'b0, 1'b0, any_perm());
               add_beat(pick_glyph(), 1'b0, 1'b0, any_perm());
               drain();
            end
         end
      end
      repeat (12) begin
         add_beat(CHAR_CR, 1'b0, 1'b1, PERM_DEDENT | any_perm());
         add_beat(pick_glyph(), 1'b0, 1'b0, any_perm());
      end
      drain();

      // Random phases, one per tab width, extremes and out-of-range widths included.
      widths[0] = 5'd1;
      widths[1] = 5'd0;
      widths[2] = 5'd31;
      widths[3] = 5'd16;
      widths[4] = 5'($urandom_range(1, 16));
      widths[5] = TAB_WIDTH_RESET;
      for (int ph = 0; ph < 6; ph++) begin
         write_tab(widths[ph]);
         paced = (ph != 3);
         goal = char_backlog.size() + 16;
         while (char_backlog.size() < goal) add_call();
         drain();
      end

      repeat (8) @(negedge clock);
      $display("Sent %0d scanner beats: directed calls, a stack-filling ladder %s",
               beats_in, "and six random tab-width phases.");
      $display("Checked %0d tokens: %0d indents (%0d on a full stack), %0d dedents, %0d newlines.",
               tokens_seen, indents_seen, drops_seen, dedents_seen, newlines_seen);
      if (failures == 0 && expected_tokens.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- indent_token_scanner.f -----
src/its_pkg.sv
src/its_if.sv
src/its_stack_cell.sv
src/its_level_stack.sv
src/indent_token_scanner.sv
bench/indent_token_scanner_tb.sv
